FILE: hw/rtl/lr_pkg.sv
`default_nettype none

package lr_pkg;

  localparam int COORD_W       = 6;
  localparam int TERM_W        = 9;
  localparam int TILE_SIZE_DEF = 64;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the segment endpoints
    logic setup;  // derive deltas, directions, step count and start term
    logic step;   // advance one pixel and fill the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic steps_zero;  // no steps left
    logic steps_one;   // the next step is the final one
    logic out_free;    // output register can take a word this cycle
  } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lr_ctrl.sv
`default_nettype none

module lr_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire lr_pkg::stat_t stat,
  output lr_pkg::cmd_t      cmd,
  output logic              in_stall
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        // zero-length segment drops straight back to idle
        if (stat.steps_zero) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.steps_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    in_stall_nxt = (state_nxt != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

  a_stall_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall_r == (state_r != ST_IDLE))
    else $error("input stall out of step with controller state");

  a_load_to_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_SETUP)
    else $error("segment load not followed by setup");

  a_step_only_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (state_r == ST_WALK && !stat.steps_zero))
    else $error("step issued outside walk or with no steps left");

endmodule

`default_nettype wire

FILE: hw/rtl/lr_dpath.sv
`default_nettype none

module lr_dpath #(
  parameter int TILE_SIZE = lr_pkg::TILE_SIZE_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire lr_pkg::cmd_t                cmd,
  output lr_pkg::stat_t                    stat,
  input  wire  [lr_pkg::COORD_W-1:0]       in_x_start,
  input  wire  [lr_pkg::COORD_W-1:0]       in_y_start,
  input  wire  [lr_pkg::COORD_W-1:0]       in_x_end,
  input  wire  [lr_pkg::COORD_W-1:0]       in_y_end,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [lr_pkg::COORD_W-1:0]       out_frag_x,
  output logic [lr_pkg::COORD_W-1:0]       out_frag_y,
  output logic                             out_last_fragment
);

  localparam int CW = lr_pkg::COORD_W;
  localparam int TW = lr_pkg::TERM_W;
  localparam logic [CW:0]   TileLim  = (CW + 1)'(TILE_SIZE);
  localparam logic [CW-1:0] CoordMax = CW'(TILE_SIZE - 1);

  function automatic logic [CW-1:0] clamp(input logic [CW-1:0] c);
    logic [CW-1:0] r;
    r = ({1'b0, c} >= TileLim) ? CoordMax : c;
    return r;
  endfunction

  // segment and walk state
  logic [CW-1:0]        cur_x_r, cur_y_r, end_x_r, end_y_r;
  logic [CW-1:0]        steps_r;
  logic                 x_major_r;
  logic [1:0]           dirs_r;        // bit 0: x decreases, bit 1: y decreases
  logic signed [TW-1:0] term_r;
  logic signed [TW-1:0] inc_lo_r;      // term update when the minor axis holds
  logic signed [TW-1:0] inc_hi_r;      // term update when the minor axis steps

  // output register
  logic                 out_valid_r;
  logic [CW-1:0]        frag_x_r, frag_y_r;
  logic                 last_r;

  // setup arithmetic
  logic          x_inc, y_inc;
  logic [CW-1:0] dx, dy, major, minor;
  logic          xm;
  logic signed [TW-1:0] minor2, major2, major1;

  always_comb begin
    x_inc  = end_x_r > cur_x_r;
    y_inc  = end_y_r > cur_y_r;
    dx     = x_inc ? (end_x_r - cur_x_r) : (cur_x_r - end_x_r);
    dy     = y_inc ? (end_y_r - cur_y_r) : (cur_y_r - end_y_r);
    xm     = dx > dy;
    major  = xm ? dx : dy;
    minor  = xm ? dy : dx;
    minor2 = $signed({{(TW-CW-1){1'b0}}, minor, 1'b0});
    major2 = $signed({{(TW-CW-1){1'b0}}, major, 1'b0});
    major1 = $signed({{(TW-CW){1'b0}}, major});
  end

  // one step along the major axis
  logic                 minor_step;
  logic [CW-1:0]        x_adv, y_adv, x_nxt, y_nxt;
  logic signed [TW-1:0] term_nxt;

  always_comb begin
    minor_step = !term_r[TW-1];
    x_adv      = dirs_r[0] ? (cur_x_r - CW'(1)) : (cur_x_r + CW'(1));
    y_adv      = dirs_r[1] ? (cur_y_r - CW'(1)) : (cur_y_r + CW'(1));
    x_nxt      = (x_major_r || minor_step) ? x_adv : cur_x_r;
    y_nxt      = (!x_major_r || minor_step) ? y_adv : cur_y_r;
    term_nxt   = minor_step ? (term_r + inc_hi_r) : (term_r + inc_lo_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x_r <= clamp(in_x_start);
      cur_y_r <= clamp(in_y_start);
      end_x_r <= clamp(in_x_end);
      end_y_r <= clamp(in_y_end);
    end
    if (cmd.setup) begin
      x_major_r <= xm;
      dirs_r    <= {!y_inc, !x_inc};
      steps_r   <= major;
      term_r    <= minor2 - major1;
      inc_lo_r  <= minor2;
      inc_hi_r  <= minor2 - major2;
    end
    if (cmd.step) begin
      cur_x_r  <= x_nxt;
      cur_y_r  <= y_nxt;
      term_r   <= term_nxt;
      steps_r  <= steps_r - CW'(1);
      frag_x_r <= x_nxt;
      frag_y_r <= y_nxt;
      last_r   <= (steps_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.steps_zero = (steps_r == '0);
  assign stat.steps_one  = (steps_r == CW'(1));
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_frag_x        = frag_x_r;
  assign out_frag_y        = frag_y_r;
  assign out_last_fragment = last_r;

  a_step_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> steps_r != '0)
    else $error("step taken with no steps left");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> out_valid_r)
    else $error("step did not load the output register");

  a_final_step_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && steps_r == CW'(1)) |=> (last_r && steps_r == '0))
    else $error("final step not flagged or count not drained");

endmodule

`default_nettype wire

FILE: hw/rtl/line_rasterizer.sv
// Channel  | Handshake           | Word
// ---------+---------------------+------------------------------------------
// input    | in_valid / in_stall | in_x_start, in_y_start, in_x_end, in_y_end
// result   | out_valid/out_stall | out_frag_x, out_frag_y, out_last_fragment
//
// A segment runs in order: capture and clamp the endpoints, set up deltas and
// the start term, then N steps of the shared step unit, N = max(|dx|, |dy|)
// (at most 63).
// A zero-length segment emits nothing.
// in_stall is high from the cycle after a segment is taken until its last
// fragment enters the output register; that register frees the walk from a
// slow consumer by one word only, so out_stall holds the walk in place.
// rst_n is synchronous and clears the controller and the output valid.
`default_nettype none

module line_rasterizer #(
  parameter int TILE_SIZE = lr_pkg::TILE_SIZE_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire  [lr_pkg::COORD_W-1:0] in_x_start,
  input  wire  [lr_pkg::COORD_W-1:0] in_y_start,
  input  wire  [lr_pkg::COORD_W-1:0] in_x_end,
  input  wire  [lr_pkg::COORD_W-1:0] in_y_end,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [lr_pkg::COORD_W-1:0] out_frag_x,
  output logic [lr_pkg::COORD_W-1:0] out_frag_y,
  output logic                       out_last_fragment
);

  lr_pkg::cmd_t  cmd;
  lr_pkg::stat_t stat;

  lr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  lr_dpath #(
    .TILE_SIZE (TILE_SIZE)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_x_start        (in_x_start),
    .in_y_start        (in_y_start),
    .in_x_end          (in_x_end),
    .in_y_end          (in_y_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frag_x        (out_frag_x),
    .out_frag_y        (out_frag_y),
    .out_last_fragment (out_last_fragment)
  );

endmodule

`default_nettype wire

FILE: test/line_rasterizer_checker.sv
module line_rasterizer_checker #(
  parameter int TILE_SIZE = lr_pkg::TILE_SIZE_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  input  wire                        in_stall,
  input  wire  [lr_pkg::COORD_W-1:0] in_x_start,
  input  wire  [lr_pkg::COORD_W-1:0] in_y_start,
  input  wire  [lr_pkg::COORD_W-1:0] in_x_end,
  input  wire  [lr_pkg::COORD_W-1:0] in_y_end,
  input  wire                        out_valid,
  input  wire                        out_stall,
  input  wire  [lr_pkg::COORD_W-1:0] out_frag_x,
  input  wire  [lr_pkg::COORD_W-1:0] out_frag_y,
  input  wire                        out_last_fragment,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [lr_pkg::COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } frag_t;

  frag_t frag_q[$];
  frag_t due;

  // shadow of the block's walker state
  coord_t                    pen_x;
  coord_t                    pen_y;
  logic [lr_pkg::TERM_W-1:0] mid_term;
  coord_t                    steps_left;
  logic                      x_major;
  logic [1:0]                step_dirs;

  function automatic int clip(coord_t c);
    return (c >= TILE_SIZE) ? TILE_SIZE - 1 : int'(c);
  endfunction

  // Walk one segment and queue every fragment it produces.
  task automatic walk_segment(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    int    x0, y0, x1, y1;
    int    dx, dy, sx, sy, n, x, y, p;
    bit    xm;
    frag_t f;
    x0 = clip(xs);
    y0 = clip(ys);
    x1 = clip(xe);
    y1 = clip(ye);
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx = (x1 > x0) ? 1 : -1;
    sy = (y1 > y0) ? 1 : -1;
    xm = dx > dy;
    n  = xm ? dx : dy;
    x  = x0;
    y  = y0;
    p  = xm ? 2 * dy - dx : 2 * dx - dy;
    x_major    = xm;
    step_dirs  = {sy < 0, sx < 0};
    steps_left = coord_t'(n);
    for (int i = 0; i < n; i++) begin
      if (xm) begin
        x += sx;
        if (p < 0) begin
          p += 2 * dy;
        end else begin
          y += sy;
          p += 2 * (dy - dx);
        end
      end else begin
        y += sy;
        if (p < 0) begin
          p += 2 * dx;
        end else begin
          x += sx;
          p += 2 * (dx - dy);
        end
      end
      f.x    = coord_t'(x);
      f.y    = coord_t'(y);
      f.last = (i == n - 1);
      frag_q.push_back(f);
      steps_left = steps_left - 1'b1;
    end
    pen_x      = coord_t'(x);
    pen_y      = coord_t'(y);
    mid_term   = p[lr_pkg::TERM_W-1:0];
    steps_left = '0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      frag_q.delete();
      pen_x      = '0;
      pen_y      = '0;
      mid_term   = '0;
      steps_left = '0;
      x_major    = 1'b0;
      step_dirs  = '0;
    end else begin
      // compare before queueing: a segment taken this edge cannot emit yet
      if (out_valid && !out_stall) begin
        if (frag_q.size() == 0) begin
          $display("%0t: unexpected fragment x=%0d y=%0d last=%0b", $time,
                   out_frag_x, out_frag_y, out_last_fragment);
          errors++;
        end else begin
          due = frag_q.pop_front();
          if (out_frag_x !== due.x || out_frag_y !== due.y ||
              out_last_fragment !== due.last) begin
            $display("%0t: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     $time, due.x, due.y, due.last,
                     out_frag_x, out_frag_y, out_last_fragment);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        walk_segment(in_x_start, in_y_start, in_x_end, in_y_end);
      end
    end
    pending = frag_q.size();
  end

endmodule

FILE: test/tb_line_rasterizer.sv
module tb_line_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [lr_pkg::COORD_W-1:0] coord_t;

  localparam int RANDOM_SEGMENTS = 140;
  localparam int QUIET_TAIL      = 30;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int COORD_MAX       = (1 << lr_pkg::COORD_W) - 1;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  coord_t in_x_start;
  coord_t in_y_start;
  coord_t in_x_end;
  coord_t in_y_end;
  logic   out_valid;
  logic   out_stall;
  coord_t out_frag_x;
  coord_t out_frag_y;
  logic   out_last_fragment;

  int fail_count;
  int frags_due;
  int idle_cycles;
  bit quiet;
  bit hold_off_req;
  bit hold_off_done;

  line_rasterizer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_x_start        (in_x_start),
    .in_y_start        (in_y_start),
    .in_x_end          (in_x_end),
    .in_y_end          (in_y_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frag_x        (out_frag_x),
    .out_frag_y        (out_frag_y),
    .out_last_fragment (out_last_fragment)
  );

  line_rasterizer_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_x_start        (in_x_start),
    .in_y_start        (in_y_start),
    .in_x_end          (in_x_end),
    .in_y_end          (in_y_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frag_x        (out_frag_x),
    .out_frag_y        (out_frag_y),
    .out_last_fragment (out_last_fragment),
    .errors            (fail_count),
    .pending           (frags_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic coord_t near(coord_t c);
    int v;
    v = int'(c) + $urandom_range(0, 8) - 4;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return coord_t'(v);
  endfunction

  // Offer one segment and hold it until taken, then maybe leave a gap.
  task automatic send_segment(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    in_valid   <= 1'b1;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end   <= xe;
    in_y_end   <= ye;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // result side: random stall bursts, one long hold-off, none at the tail
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    coord_t xs, ys, xe, ye;
    int     kind;
    quiet         = 1'b0;
    hold_off_req  = 1'b0;
    hold_off_done = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_x_start <= '0;
    in_y_start <= '0;
    in_x_end   <= '0;
    in_y_end   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // zero-length segments
    send_segment(6'd5, 6'd7, 6'd5, 6'd7);
    send_segment(6'd0, 6'd0, 6'd0, 6'd0);
    send_segment(6'd63, 6'd63, 6'd63, 6'd63);
    // axis-aligned, both directions, full length
    send_segment(6'd0, 6'd0, 6'd63, 6'd0);
    send_segment(6'd63, 6'd10, 6'd0, 6'd10);
    send_segment(6'd20, 6'd0, 6'd20, 6'd63);
    send_segment(6'd20, 6'd63, 6'd20, 6'd0);
    // diagonals: tie puts y on the major axis
    send_segment(6'd0, 6'd0, 6'd63, 6'd63);
    send_segment(6'd63, 6'd63, 6'd0, 6'd0);
    send_segment(6'd63, 6'd0, 6'd0, 6'd63);
    send_segment(6'd0, 6'd63, 6'd63, 6'd0);
    send_segment(6'd21, 6'd42, 6'd42, 6'd21);
    // shallow and steep extremes
    send_segment(6'd0, 6'd0, 6'd63, 6'd1);
    send_segment(6'd0, 6'd0, 6'd1, 6'd63);
    send_segment(6'd0, 6'd63, 6'd62, 6'd0);
    send_segment(6'd40, 6'd5, 6'd3, 6'd20);
    send_segment(6'd30, 6'd30, 6'd25, 6'd40);
    // single steps
    send_segment(6'd10, 6'd10, 6'd11, 6'd10);
    send_segment(6'd10, 6'd10, 6'd10, 6'd9);
    send_segment(6'd10, 6'd10, 6'd11, 6'd11);
    send_segment(6'd32, 6'd31, 6'd31, 6'd32);

    // back up the output while segments keep coming
    hold_off_req = 1'b1;

    for (int i = 0; i < RANDOM_SEGMENTS; i++) begin
      if (i >= RANDOM_SEGMENTS - QUIET_TAIL) quiet = 1'b1;
      kind = $urandom_range(0, 9);
      xs = coord_t'($urandom_range(0, COORD_MAX));
      ys = coord_t'($urandom_range(0, COORD_MAX));
      xe = coord_t'($urandom_range(0, COORD_MAX));
      ye = coord_t'($urandom_range(0, COORD_MAX));
      if (kind == 6 || kind == 7) begin
        xe = near(xs);
        ye = near(ys);
      end else if (kind == 8) begin
        case ($urandom_range(0, 2))
          0: ye = ys;
          1: xe = xs;
          default: begin
            ye = (ys + xe > xs) ? coord_t'(ys + (xe - xs)) : ys;
            xe = coord_t'(xs + (ye - ys));
          end
        endcase
      end else if (kind == 9) begin
        xe = xs;
        ye = ys;
      end
      send_segment(xs, ys, xe, ye);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (frags_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
